[hw/rtl/crtr_pkg.sv]
// Shared constants, instruction encodings and transaction types of the call/return trace recorder.
package crtr_pkg;

	localparam int TRACE_ENTRIES = 1024;
	localparam int SLOT_BITS     = $clog2(TRACE_ENTRIES);
	localparam int WORD_BITS     = 32;
	localparam int DEPTH_BITS    = 16;
	localparam int EDEPTH_BITS   = DEPTH_BITS + 1;
	localparam int INDEX_BITS    = 10;

	localparam logic [DEPTH_BITS-1:0] DEPTH_MAX = {DEPTH_BITS{1'b1}};
	localparam logic [SLOT_BITS-1:0]  SLOT_LAST = SLOT_BITS'(TRACE_ENTRIES - 1);

	localparam logic [31:0] W_ECALL  = 32'h0000_0073;
	localparam logic [31:0] W_MRET   = 32'h3020_0073;
	localparam logic [31:0] W_SRET   = 32'h1020_0073;
	localparam logic [31:0] W_RET    = 32'h0000_8067;
	localparam logic [31:0] W_EBREAK = 32'h0010_0073;
	localparam logic [6:0]  OPC_JAL  = 7'b1101111;
	localparam logic [6:0]  OPC_JALR = 7'b1100111;
	localparam logic [11:0] LOW_JAL  = 12'h06f;
	localparam logic [11:0] LOW_JALR = 12'h067;

	localparam logic OP_RECORD = 1'b0;
	localparam logic OP_READ   = 1'b1;

	typedef struct packed {
		logic [WORD_BITS-1:0]   pc;
		logic [WORD_BITS-1:0]   next_pc;
		logic [31:0]            instr;
		logic [WORD_BITS-1:0]   cause;
		logic                   is_intr;
		logic                   is_return;
		logic [EDEPTH_BITS-1:0] depth;
	} entry_t;

	typedef struct packed {
		logic                  recorded;
		entry_t                entry;
		logic [SLOT_BITS-1:0]  write_slot;
		logic [DEPTH_BITS-1:0] current_depth;
		logic [DEPTH_BITS-1:0] peak_depth;
	} result_t;

endpackage

[hw/rtl/call_return_trace_recorder.sv]
// Call/return trace recorder: event classification, depth tracking, trace memory and output queue.
//
// Usage: the input channel (in_valid/in_stall) carries one transaction per retired
// instruction (op = record) or a trace lookup (op = read, slot read_index). The output
// channel (out_valid/out_stall) returns exactly one transaction per input transaction,
// in order. A record transaction reports whether an entry was written and its contents;
// a read transaction returns the stored entry. Both report write_slot, current_depth and
// peak_depth as they stand after the transaction.
// Each result is registered in the s1 stage and then written into the output queue, after
// which out_valid rises. Throughput: one transaction per cycle while in_stall is low; the
// trace memory is written and read in the acceptance cycle, and its registered read data
// is resolved in the following stage, so a read right after a record of the same slot
// already sees the new entry.
// A three-entry output queue absorbs results; in_stall rises only when the queue and the
// stage in flight could not take another transaction, so a stalled receiver holds the
// input side back after at most three more transactions.
// Reset (arst_n low) clears the head slot, depth counters, trap flag, s1 valid flag and queue
// pointers and count; trace memory, s1 data and queue entries stay undefined until written.
module call_return_trace_recorder (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic                             op,
	input  logic [crtr_pkg::WORD_BITS-1:0]   pc,
	input  logic [crtr_pkg::WORD_BITS-1:0]   next_pc,
	input  logic [31:0]                      instr_word,
	input  logic                             intr_valid,
	input  logic [crtr_pkg::WORD_BITS-1:0]   intr_code,
	input  logic [crtr_pkg::INDEX_BITS-1:0]  read_index,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic                             recorded,
	output logic [crtr_pkg::WORD_BITS-1:0]   entry_pc,
	output logic [crtr_pkg::WORD_BITS-1:0]   entry_next_pc,
	output logic [31:0]                      entry_instr,
	output logic                             entry_is_intr,
	output logic [crtr_pkg::WORD_BITS-1:0]   entry_cause,
	output logic                             entry_is_return,
	output logic signed [crtr_pkg::EDEPTH_BITS-1:0] entry_depth,
	output logic [crtr_pkg::SLOT_BITS-1:0]   write_slot,
	output logic [crtr_pkg::DEPTH_BITS-1:0]  current_depth,
	output logic [crtr_pkg::DEPTH_BITS-1:0]  peak_depth
);
	import crtr_pkg::*;

	localparam int QDEPTH = 3;

	entry_t                trace_mem [TRACE_ENTRIES];
	entry_t                rd_data_s1;

	logic [SLOT_BITS-1:0]  head_q;
	logic [DEPTH_BITS-1:0] depth_q;
	logic [DEPTH_BITS-1:0] peak_q;
	logic                  in_trap_q;

	logic                  valid_s1;
	logic                  op_s1;
	result_t               res_s1;

	result_t               queue_q [QDEPTH];
	logic [1:0]            rd_ptr_q;
	logic [1:0]            wr_ptr_q;
	logic [1:0]            cnt_q;

	logic                  accept;
	logic                  pop;
	logic                  is_call;
	logic                  is_ret;
	logic                  event_hit;
	logic                  in_trap_d;
	logic [DEPTH_BITS-1:0] depth_d;
	logic [DEPTH_BITS-1:0] peak_d;
	logic [SLOT_BITS-1:0]  head_d;
	logic [EDEPTH_BITS-1:0] edepth;
	entry_t                wr_entry;
	result_t               res_d;
	result_t               push_data;
	result_t               head_res;

	assign in_stall = ({1'b0, cnt_q} + {2'b00, valid_s1}) >= 3'(QDEPTH);
	assign accept   = in_valid && !in_stall;
	assign out_valid = cnt_q != 2'd0;
	assign pop      = out_valid && !out_stall;

	always_comb begin
		is_call   = 1'b0;
		is_ret    = 1'b0;
		in_trap_d = in_trap_q;
		priority if (intr_valid) begin
			is_call   = 1'b1;
			in_trap_d = 1'b1;
		end else if (instr_word == W_ECALL || instr_word == W_EBREAK) begin
			is_call = 1'b1;
		end else if (instr_word == W_RET) begin
			is_ret = 1'b1;
		end else if (instr_word == W_MRET || instr_word == W_SRET) begin
			is_ret    = in_trap_q;
			in_trap_d = 1'b0;
		end else if (instr_word[6:0] == OPC_JAL) begin
			is_call = instr_word[11:0] != LOW_JAL;
		end else if (instr_word[6:0] == OPC_JALR) begin
			is_call = instr_word[11:0] != LOW_JALR;
		end
		event_hit = is_call || is_ret;

		depth_d = depth_q;
		edepth  = {1'b0, depth_q};
		if (is_call) begin
			if (depth_q != DEPTH_MAX) begin
				depth_d = depth_q + 1'b1;
			end
		end else if (is_ret) begin
			if (depth_q == '0) begin
				edepth = '1;
			end else begin
				depth_d = depth_q - 1'b1;
				edepth  = {1'b0, depth_q - 1'b1};
			end
		end
		peak_d = (depth_d > peak_q) ? depth_d : peak_q;
		head_d = event_hit ? ((head_q == SLOT_LAST) ? '0 : head_q + 1'b1) : head_q;

		wr_entry.pc        = pc;
		wr_entry.next_pc   = next_pc;
		wr_entry.instr     = instr_word;
		wr_entry.cause     = intr_valid ? intr_code : '0;
		wr_entry.is_intr   = intr_valid;
		wr_entry.is_return = is_ret;
		wr_entry.depth     = edepth;

		res_d.recorded      = (op == OP_RECORD) && event_hit;
		res_d.entry         = res_d.recorded ? wr_entry : '0;
		res_d.write_slot    = (op == OP_RECORD) ? head_d : head_q;
		res_d.current_depth = (op == OP_RECORD && event_hit) ? depth_d : depth_q;
		res_d.peak_depth    = (op == OP_RECORD && event_hit) ? peak_d : peak_q;
	end

	always_ff @(posedge clk) begin
		if (accept && op == OP_RECORD && event_hit) begin
			trace_mem[head_q] <= wr_entry;
		end
		if (accept && op == OP_READ) begin
			rd_data_s1 <= trace_mem[read_index[SLOT_BITS-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q    <= '0;
			depth_q   <= '0;
			peak_q    <= '0;
			in_trap_q <= 1'b0;
			valid_s1  <= 1'b0;
		end else begin
			valid_s1 <= accept;
			if (accept && op == OP_RECORD) begin
				in_trap_q <= in_trap_d;
				if (event_hit) begin
					head_q  <= head_d;
					depth_q <= depth_d;
					peak_q  <= peak_d;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1  <= op;
			res_s1 <= res_d;
		end
	end

	always_comb begin
		push_data = res_s1;
		if (op_s1 == OP_READ) begin
			push_data.entry = rd_data_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= '0;
			wr_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (valid_s1) begin
				wr_ptr_q <= (wr_ptr_q == 2'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == 2'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			cnt_q <= cnt_q + {1'b0, valid_s1} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			queue_q[wr_ptr_q] <= push_data;
		end
	end

	assign head_res        = queue_q[rd_ptr_q];
	assign recorded        = head_res.recorded;
	assign entry_pc        = head_res.entry.pc;
	assign entry_next_pc   = head_res.entry.next_pc;
	assign entry_instr     = head_res.entry.instr;
	assign entry_is_intr   = head_res.entry.is_intr;
	assign entry_cause     = head_res.entry.cause;
	assign entry_is_return = head_res.entry.is_return;
	assign entry_depth     = $signed(head_res.entry.depth);
	assign write_slot      = head_res.write_slot;
	assign current_depth   = head_res.current_depth;
	assign peak_depth      = head_res.peak_depth;

endmodule

[dv/tb_call_return_trace_recorder.sv]
// Self-checking testbench for the call/return trace recorder with its own event predictor.
module tb_call_return_trace_recorder;

	import crtr_pkg::*;

	localparam logic [31:0] W_NOP = 32'h0000_0013;

	typedef struct {
		logic                  op;
		logic [WORD_BITS-1:0]  pc;
		logic [WORD_BITS-1:0]  next_pc;
		logic [31:0]           instr;
		logic                  intr;
		logic [WORD_BITS-1:0]  cause;
		logic [INDEX_BITS-1:0] read_index;
	} retire_item_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic op = OP_RECORD;
	logic [WORD_BITS-1:0] pc = '0;
	logic [WORD_BITS-1:0] next_pc = '0;
	logic [31:0] instr_word = '0;
	logic intr_valid = 1'b0;
	logic [WORD_BITS-1:0] intr_code = '0;
	logic [INDEX_BITS-1:0] read_index = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic recorded;
	logic [WORD_BITS-1:0] entry_pc;
	logic [WORD_BITS-1:0] entry_next_pc;
	logic [31:0] entry_instr;
	logic entry_is_intr;
	logic [WORD_BITS-1:0] entry_cause;
	logic entry_is_return;
	logic signed [EDEPTH_BITS-1:0] entry_depth;
	logic [SLOT_BITS-1:0] write_slot;
	logic [DEPTH_BITS-1:0] current_depth;
	logic [DEPTH_BITS-1:0] peak_depth;

	entry_t trace_mem [TRACE_ENTRIES];
	logic [SLOT_BITS-1:0] next_slot = '0;
	logic [DEPTH_BITS-1:0] call_depth = '0;
	logic [DEPTH_BITS-1:0] call_peak = '0;
	logic trap_open = 1'b0;
	int filled_slots = 0;

	result_t due_reports [$];
	result_t want_report;
	int fail_count = 0;
	bit idle_on = 1'b1;
	int hold_request = 0;

	call_return_trace_recorder i_dut (.*);

	always #5 clk = ~clk;

	function automatic result_t classify_and_record(input retire_item_t it);
		result_t res;
		logic is_call;
		logic is_ret;
		logic [EDEPTH_BITS-1:0] edepth;
		res = '0;
		is_call = 1'b0;
		is_ret = 1'b0;
		if (it.op == OP_READ) begin
			res.entry = trace_mem[it.read_index];
		end else begin
			if (it.intr) begin
				is_call = 1'b1;
				trap_open = 1'b1;
			end else if (it.instr == W_ECALL || it.instr == W_EBREAK) begin
				is_call = 1'b1;
			end else if (it.instr == W_RET) begin
				is_ret = 1'b1;
			end else if (it.instr == W_MRET || it.instr == W_SRET) begin
				is_ret = trap_open;
				trap_open = 1'b0;
			end else if (it.instr[6:0] == OPC_JAL) begin
				is_call = it.instr[11:0] != LOW_JAL;
			end else if (it.instr[6:0] == OPC_JALR) begin
				is_call = it.instr[11:0] != LOW_JALR;
			end
			if (is_call || is_ret) begin
				if (is_call) begin
					edepth = {1'b0, call_depth};
					if (call_depth != DEPTH_MAX) call_depth++;
				end else if (call_depth == '0) begin
					edepth = '1;
				end else begin
					call_depth--;
					edepth = {1'b0, call_depth};
				end
				if (call_depth > call_peak) call_peak = call_depth;
				trace_mem[next_slot].pc = it.pc;
				trace_mem[next_slot].next_pc = it.next_pc;
				trace_mem[next_slot].instr = it.instr;
				trace_mem[next_slot].cause = it.intr ? it.cause : '0;
				trace_mem[next_slot].is_intr = it.intr;
				trace_mem[next_slot].is_return = is_ret;
				trace_mem[next_slot].depth = edepth;
				res.recorded = 1'b1;
				res.entry = trace_mem[next_slot];
				if (next_slot == SLOT_LAST) next_slot = '0;
				else next_slot++;
				if (filled_slots < TRACE_ENTRIES) filled_slots++;
			end
		end
		res.write_slot = next_slot;
		res.current_depth = call_depth;
		res.peak_depth = call_peak;
		return res;
	endfunction

	function automatic int pick_gap();
		int roll;
		if (!idle_on) return 0;
		roll = $urandom_range(99, 0);
		if (roll < 65) return 0;
		if (roll < 93) return $urandom_range(3, 1);
		return $urandom_range(40, 8);
	endfunction

	function automatic retire_item_t record_item(input logic [31:0] word, input logic intr);
		retire_item_t it;
		it.op = OP_RECORD;
		it.pc = $urandom();
		it.next_pc = $urandom();
		it.instr = word;
		it.intr = intr;
		it.cause = $urandom();
		it.read_index = INDEX_BITS'($urandom());
		return it;
	endfunction

	function automatic retire_item_t read_item(input logic [INDEX_BITS-1:0] idx);
		retire_item_t it;
		it = record_item($urandom(), 1'b0);
		it.op = OP_READ;
		it.read_index = idx;
		return it;
	endfunction

	function automatic logic [31:0] call_word();
		case ($urandom_range(3, 0))
			0: return {20'($urandom()), 5'($urandom_range(31, 1)), OPC_JAL};
			1: return {20'($urandom()), 5'($urandom_range(31, 1)), OPC_JALR};
			2: return W_ECALL;
			default: return W_EBREAK;
		endcase
	endfunction

	function automatic logic [31:0] plain_jump_word();
		logic [31:0] word;
		word = {20'($urandom()), 5'd0, ($urandom_range(1, 0) != 0) ? OPC_JAL : OPC_JALR};
		if (word == W_RET) word = {20'd0, LOW_JALR};
		return word;
	endfunction

	function automatic retire_item_t random_item();
		int roll;
		roll = $urandom_range(99, 0);
		if (roll < 35) return record_item(call_word(), 1'b0);
		if (roll < 43) return record_item($urandom(), 1'b1);
		if (roll < 68) return record_item(W_RET, 1'b0);
		if (roll < 74) return record_item(roll[0] ? W_MRET : W_SRET, 1'b0);
		if (roll < 80) return record_item(plain_jump_word(), 1'b0);
		if (roll < 88 || filled_slots == 0) return record_item($urandom(), 1'b0);
		return read_item(INDEX_BITS'($urandom_range(filled_slots - 1, 0)));
	endfunction

	task automatic send_item(input retire_item_t it);
		int gap;
		gap = pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		op <= it.op;
		pc <= it.pc;
		next_pc <= it.next_pc;
		instr_word <= it.instr;
		intr_valid <= it.intr;
		intr_code <= it.cause;
		read_index <= it.read_index;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		due_reports.push_back(classify_and_record(it));
	endtask

	task automatic send_fixed(input logic [31:0] word, input logic intr,
			input logic [WORD_BITS-1:0] addr, input logic [WORD_BITS-1:0] cause);
		retire_item_t it;
		it = record_item(word, intr);
		it.pc = addr;
		it.next_pc = ~addr;
		it.cause = cause;
		send_item(it);
	endtask

	task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
		if (want !== got) begin
			fail_count++;
			if (fail_count <= 10) $display("mismatch on %s: expected %h, got %h", name, want, got);
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (due_reports.size() == 0) begin
				fail_count++;
				if (fail_count <= 10) $display("unexpected result transaction at %0t", $realtime);
			end else begin
				want_report = due_reports.pop_front();
				check_field("recorded", want_report.recorded, recorded);
				check_field("entry_pc", want_report.entry.pc, entry_pc);
				check_field("entry_next_pc", want_report.entry.next_pc, entry_next_pc);
				check_field("entry_instr", want_report.entry.instr, entry_instr);
				check_field("entry_is_intr", want_report.entry.is_intr, entry_is_intr);
				check_field("entry_cause", want_report.entry.cause, entry_cause);
				check_field("entry_is_return", want_report.entry.is_return, entry_is_return);
				check_field("entry_depth", want_report.entry.depth, $unsigned(entry_depth));
				check_field("write_slot", want_report.write_slot, write_slot);
				check_field("current_depth", want_report.current_depth, current_depth);
				check_field("peak_depth", want_report.peak_depth, peak_depth);
			end
		end
	end

	initial begin : receiver
		int stall_left;
		int hold_left;
		stall_left = 0;
		hold_left = 0;
		forever begin
			@(negedge clk);
			if (hold_request > 0) begin
				hold_left = hold_request;
				hold_request = 0;
			end
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else if (stall_left > 0) begin
				out_stall <= 1'b1;
				stall_left--;
			end else begin
				out_stall <= 1'b0;
				stall_left = pick_gap();
			end
		end
	end

	task automatic test_directed();
		send_fixed(W_NOP, 1'b0, '0, '0);
		send_fixed(W_RET, 1'b0, '1, '1);
		send_fixed(W_MRET, 1'b0, 32'h0000_1000, '0);
		send_fixed(W_SRET, 1'b0, 32'h0000_1004, '0);
		send_fixed({20'hfffff, 5'd1, OPC_JAL}, 1'b0, '1, '0);
		send_fixed({20'h00000, 5'd31, OPC_JALR}, 1'b0, 32'h8000_0000, '0);
		send_fixed(W_ECALL, 1'b0, 32'h0000_2000, 32'hdead_beef);
		send_fixed(W_EBREAK, 1'b0, 32'h0000_2004, '1);
		send_fixed(W_MRET, 1'b1, 32'h0000_3000, '1);
		send_fixed(W_SRET, 1'b0, 32'h0000_3004, '0);
		send_fixed(W_MRET, 1'b0, 32'h0000_3008, '0);
		send_fixed($urandom(), 1'b1, 32'h0000_4000, '0);
		send_fixed(W_MRET, 1'b0, 32'h0000_4004, '0);
		send_fixed({20'h12345, 5'd0, OPC_JAL}, 1'b0, 32'h0000_5000, '0);
		send_fixed({20'd0, LOW_JALR}, 1'b0, 32'h0000_5004, '0);
		send_fixed(W_RET, 1'b0, 32'h0000_6000, '0);
		send_fixed(W_RET, 1'b0, 32'h0000_6004, '0);
		send_fixed(W_RET, 1'b0, 32'h0000_6008, '0);
		send_fixed(W_RET, 1'b0, 32'h0000_600c, '0);
		send_fixed(W_RET, 1'b0, 32'h0000_6010, '0);
		send_item(read_item('0));
		send_item(read_item(INDEX_BITS'(filled_slots - 1)));
		send_item(read_item(INDEX_BITS'(filled_slots / 2)));
	endtask

	task automatic test_random_traffic();
		for (int n = 0; n < 1650; n++) begin
			idle_on = (n % 400) < 300;
			send_item(random_item());
		end
		idle_on = 1'b1;
	endtask

	task automatic test_output_backpressure();
		idle_on = 1'b0;
		hold_request = 150;
		repeat (40) send_item(random_item());
		idle_on = 1'b1;
	endtask

	task automatic test_call_burst();
		idle_on = 1'b0;
		repeat (24) send_item(record_item(call_word(), 1'b0));
		idle_on = 1'b1;
		repeat (24) send_item(record_item(W_RET, 1'b0));
		repeat (4) send_item(record_item(call_word(), 1'b0));
	endtask

	task automatic test_read_sweep();
		send_item(read_item('0));
		if (filled_slots == TRACE_ENTRIES) begin
			send_item(read_item(SLOT_LAST));
			send_item(read_item(10'h155));
			send_item(read_item(10'h2aa));
		end
		repeat (20) send_item(read_item(INDEX_BITS'($urandom_range(filled_slots - 1, 0))));
	endtask

	initial begin
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_random_traffic();
		test_output_backpressure();
		test_call_burst();
		test_read_sweep();
		@(negedge clk);
		in_valid <= 1'b0;
		while (due_reports.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (fail_count == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

	initial begin
		#20_000_000;
		$display("Verification failed");
		$finish;
	end

endmodule

[filelist.f]
hw/rtl/crtr_pkg.sv
hw/rtl/call_return_trace_recorder.sv
dv/tb_call_return_trace_recorder.sv
